>>> sv/assert_macros.svh
// Assertion macros for the RTL, included by roulette_wheel_selector.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/rws_pkg.sv
package rws_pkg;

    localparam int MAX_POPULATION = 256;
    localparam int FITNESS_BITS   = 16;

    localparam int FIT_IN_W  = 16;
    localparam int FRAC_W    = 16;
    localparam int FIT_USE_W = (FITNESS_BITS < FIT_IN_W) ? FITNESS_BITS : FIT_IN_W;
    localparam int IDX_W     = $clog2(MAX_POPULATION);
    localparam int CNT_W     = $clog2(MAX_POPULATION + 1);
    localparam int TOT_W     = FITNESS_BITS + IDX_W;
    localparam int PROD_W    = TOT_W + FRAC_W;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SELECT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEARCH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                action;
        logic                start_new;
        logic [FIT_IN_W-1:0] fitness_value;
        logic [FRAC_W-1:0]   random_fraction;
    } t_in_item;

    // Upper midpoint of the search interval, lo + (hi - lo + 1) / 2.
    function automatic logic [IDX_W-1:0] f_mid(input logic [IDX_W-1:0] lo,
                                               input logic [IDX_W-1:0] hi);
        logic [IDX_W:0] span;
        span = {1'b0, hi} - {1'b0, lo} + (IDX_W + 1)'(1);
        return lo + span[IDX_W:1];
    endfunction

endpackage

>>> sv/rws_channels.sv
interface rws_in_if import rws_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                action;
    logic                start_new;
    logic [FIT_IN_W-1:0] fitness_value;
    logic [FRAC_W-1:0]   random_fraction;

    modport source (output valid, action, start_new, fitness_value, random_fraction,
                    input ready);
    modport sink (input valid, action, start_new, fitness_value, random_fraction,
                  output ready);
endinterface

interface rws_out_if import rws_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] selected_index;
    logic [CNT_W-1:0] loaded_count;
    logic             error_flag;

    modport source (output valid, selected_index, loaded_count, error_flag,
                    input ready);
    modport sink (input valid, selected_index, loaded_count, error_flag,
                  output ready);
endinterface

>>> sv/rws_prefix_ram.sv
module rws_prefix_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/roulette_wheel_selector.sv
// Fitness-proportionate (roulette wheel) selector. Each beat on the input channel
// either loads one fitness value, appending it to the population and storing the
// running fitness sum before it as that individual's lower bound, or asks for one
// selection, where the random fraction is scaled by the total fitness and the
// lower-bound table is binary-searched for the last individual whose bound does not
// exceed the target. A load into a full table, or a selection with no population,
// returns the error flag instead. Every input beat gives exactly one output beat. A
// load passes through the execute and done states to the output register; a
// selection also makes at most ceil(log2(population)) search steps. The search makes
// one probe of the prefix RAM per cycle through its single registered read port. A
// new beat is accepted once the previous result has moved into the output register.
`include "assert_macros.svh"

module roulette_wheel_selector import rws_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rws_in_if.sink    i_in,
    rws_out_if.source o_out
);

    t_state           r_state, n_state;
    t_in_item         r_item, n_item;
    logic [CNT_W-1:0] r_pop, n_pop;
    logic [TOT_W-1:0] r_total, n_total;
    logic [TOT_W-1:0] r_target, n_target;
    logic [IDX_W-1:0] r_lo, n_lo;
    logic [IDX_W-1:0] r_hi, n_hi;
    logic [IDX_W-1:0] r_mid, n_mid;
    logic [IDX_W-1:0] r_res_idx, n_res_idx;
    logic             r_res_err, n_res_err;
    logic             r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_out_idx, n_out_idx;
    logic [CNT_W-1:0] r_out_cnt, n_out_cnt;
    logic             r_out_err, n_out_err;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [TOT_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [TOT_W-1:0] ram_rdata;

    logic [PROD_W-1:0] w_prod;
    logic [CNT_W-1:0]  w_eff_pop;
    logic [TOT_W-1:0]  w_eff_total;
    logic [IDX_W-1:0]  w_last;
    logic              w_le;
    logic [IDX_W-1:0]  w_lo, w_hi;

    rws_prefix_ram #(
        .DEPTH (MAX_POPULATION),
        .WIDTH (TOT_W)
    ) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign w_prod = PROD_W'(r_total) * PROD_W'(r_item.random_fraction);

    assign w_eff_pop   = (r_item.start_new && r_item.action == ACT_LOAD) ? '0 : r_pop;
    assign w_eff_total = (r_item.start_new && r_item.action == ACT_LOAD) ? '0 : r_total;
    assign w_last      = IDX_W'(r_pop - CNT_W'(1));

    assign w_le = (ram_rdata <= r_target);
    assign w_lo = w_le ? r_mid : r_lo;
    assign w_hi = w_le ? r_hi : r_mid - IDX_W'(1);

    assign i_in.ready           = (r_state == ST_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.selected_index = r_out_idx;
    assign o_out.loaded_count   = r_out_cnt;
    assign o_out.error_flag     = r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pop       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pop       <= n_pop;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_target  <= n_target;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_res_idx <= n_res_idx;
        r_res_err <= n_res_err;
        r_out_idx <= n_out_idx;
        r_out_cnt <= n_out_cnt;
        r_out_err <= n_out_err;
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_pop       = r_pop;
        n_total     = r_total;
        n_target    = r_target;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_res_idx   = r_res_idx;
        n_res_err   = r_res_err;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_idx   = r_out_idx;
        n_out_cnt   = r_out_cnt;
        n_out_err   = r_out_err;
        ram_we      = 1'b0;
        ram_waddr   = w_eff_pop[IDX_W-1:0];
        ram_wdata   = w_eff_total;
        ram_raddr   = r_mid;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_item.action          = i_in.action;
                    n_item.start_new       = i_in.start_new;
                    n_item.fitness_value   = i_in.fitness_value;
                    n_item.random_fraction = i_in.random_fraction;
                    n_state                = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_res_idx = '0;
                n_res_err = 1'b0;
                n_state   = ST_DONE;
                if (r_item.action == ACT_LOAD) begin
                    n_pop   = w_eff_pop;
                    n_total = w_eff_total;
                    if (w_eff_pop == CNT_W'(MAX_POPULATION)) begin
                        n_res_err = 1'b1;
                    end else begin
                        ram_we    = 1'b1;
                        n_total   = w_eff_total
                                  + TOT_W'(r_item.fitness_value[FIT_USE_W-1:0]);
                        n_pop     = w_eff_pop + CNT_W'(1);
                        n_res_idx = w_eff_pop[IDX_W-1:0];
                    end
                end else if (r_pop == '0) begin
                    n_res_err = 1'b1;
                end else begin
                    n_target = w_prod[PROD_W-1:FRAC_W];
                    n_lo     = '0;
                    n_hi     = w_last;
                    if (w_last != '0) begin
                        n_mid     = f_mid('0, w_last);
                        ram_raddr = n_mid;
                        n_state   = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                n_lo = w_lo;
                n_hi = w_hi;
                if (w_lo < w_hi) begin
                    n_mid     = f_mid(w_lo, w_hi);
                    ram_raddr = n_mid;
                end else begin
                    n_res_idx = w_lo;
                    n_state   = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_res_idx;
                    n_out_cnt   = r_pop;
                    n_out_err   = r_res_err;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `RWS_ASSERT_IMP(a_pop_bound, i_clk, i_rst_n, 1'b1, r_pop <= CNT_W'(MAX_POPULATION), "population count beyond capacity")
    `RWS_ASSERT_IMP(a_search_interval, i_clk, i_rst_n, r_state == ST_SEARCH, (r_lo < r_hi) && (CNT_W'(r_hi) < r_pop), "search interval out of range")
    `RWS_ASSERT_NXT(a_done_leaves, i_clk, i_rst_n, (r_state == ST_DONE) && (!r_out_valid || o_out.ready), (r_state == ST_IDLE) && r_out_valid, "finished result not handed to output register")

endmodule

>>> test/tb_roulette_wheel_selector.sv
`timescale 1ns / 100ps

module tb_roulette_wheel_selector import rws_pkg::*; ();

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [CNT_W-1:0] count;
        logic             error;
    } t_pick;

    logic i_clk;
    logic i_rst_n;

    rws_in_if  in_ch ();
    rws_out_if out_ch ();

    roulette_wheel_selector u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [TOT_W-1:0] lower_bound [MAX_POPULATION];
    logic [CNT_W-1:0] held_count;
    logic [TOT_W-1:0] fitness_total;

    t_pick pending_picks [$];
    int    mismatch_count;
    int    sender_idle_pct;
    int    receiver_stall_pct;
    int    hold_off_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_pick predict_pick(input t_in_item item);
        t_pick            pick;
        logic [PROD_W-1:0] scaled;
        logic [TOT_W-1:0]  target;
        int                lo;
        int                hi;
        int                mid;
        pick = '0;
        if (item.action == ACT_LOAD) begin
            if (item.start_new) begin
                held_count    = '0;
                fitness_total = '0;
            end
            if (held_count >= MAX_POPULATION) begin
                pick.error = 1'b1;
            end else begin
                lower_bound[held_count[IDX_W-1:0]] = fitness_total;
                fitness_total = fitness_total + TOT_W'(item.fitness_value[FIT_USE_W-1:0]);
                pick.index    = held_count[IDX_W-1:0];
                held_count    = held_count + CNT_W'(1);
            end
        end else if (held_count == 0) begin
            pick.error = 1'b1;
        end else begin
            scaled = PROD_W'(fitness_total) * PROD_W'(item.random_fraction);
            target = TOT_W'(scaled >> FRAC_W);
            lo = 0;
            hi = int'(held_count) - 1;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                if (lower_bound[IDX_W'(mid)] <= target) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
            pick.index = IDX_W'(lo);
        end
        pick.count = held_count;
        return pick;
    endfunction

    function automatic logic [FIT_IN_W-1:0] random_fitness();
        int roll;
        roll = $urandom_range(99);
        if (roll < 20) begin
            return '0;
        end else if (roll < 30) begin
            return '1;
        end else if (roll < 60) begin
            return FIT_IN_W'($urandom_range(15));
        end
        return FIT_IN_W'($urandom);
    endfunction

    function automatic logic [FRAC_W-1:0] random_fraction();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5) begin
            return '0;
        end else if (roll < 10) begin
            return '1;
        end
        return FRAC_W'($urandom);
    endfunction

    function automatic t_in_item load_beat(input logic fresh, input logic [FIT_IN_W-1:0] fit);
        t_in_item item;
        item.action          = ACT_LOAD;
        item.start_new       = fresh;
        item.fitness_value   = fit;
        item.random_fraction = FRAC_W'($urandom);
        return item;
    endfunction

    function automatic t_in_item select_beat(input logic [FRAC_W-1:0] frac);
        t_in_item item;
        item.action          = ACT_SELECT;
        item.start_new       = 1'($urandom);
        item.fitness_value   = FIT_IN_W'($urandom);
        item.random_fraction = frac;
        return item;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    task automatic check_pick();
        t_pick want;
        if (pending_picks.size() == 0) begin
            report_mismatch("unexpected result beat, index", out_ch.selected_index, -1);
        end else begin
            want = pending_picks.pop_front();
            if (out_ch.selected_index !== want.index) begin
                report_mismatch("selected_index", out_ch.selected_index, want.index);
            end
            if (out_ch.loaded_count !== want.count) begin
                report_mismatch("loaded_count", out_ch.loaded_count, want.count);
            end
            if (out_ch.error_flag !== want.error) begin
                report_mismatch("error_flag", out_ch.error_flag, want.error);
            end
        end
    endtask

    initial begin : result_sink
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                check_pick();
            end
            if (hold_off_cycles > 0) begin
                out_ch.ready <= 1'b0;
                hold_off_cycles--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    task automatic send_beat(input t_in_item item);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.action          <= item.action;
        in_ch.start_new       <= item.start_new;
        in_ch.fitness_value   <= item.fitness_value;
        in_ch.random_fraction <= item.random_fraction;
        do begin
            @(posedge i_clk);
        end while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
        pending_picks = {pending_picks, predict_pick(item)};
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_picks.size() != 0);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
    endtask

    task automatic test_empty_select();
        send_beat(select_beat(16'h1234));
        send_beat(select_beat('1));
        wait_for_results();
    endtask

    task automatic test_field_extremes();
        t_in_item item;
        send_beat(load_beat(1'b1, '1));
        send_beat(load_beat(1'b0, '0));
        send_beat(load_beat(1'b0, '1));
        send_beat(load_beat(1'b0, 16'h0001));
        send_beat(select_beat('0));
        send_beat(select_beat('1));
        send_beat(select_beat(16'h8000));
        item = select_beat(16'h7FFF);
        item.start_new = 1'b1;
        send_beat(item);
        send_beat(load_beat(1'b1, 16'h8000));
        send_beat(select_beat('1));
        wait_for_results();
    endtask

    task automatic test_all_zero_fitness();
        send_beat(load_beat(1'b1, '0));
        repeat (3) send_beat(load_beat(1'b0, '0));
        send_beat(select_beat('0));
        send_beat(select_beat('1));
        send_beat(select_beat(random_fraction()));
        wait_for_results();
    endtask

    task automatic test_full_population();
        send_beat(load_beat(1'b1, '1));
        repeat (MAX_POPULATION - 1) send_beat(load_beat(1'b0, '1));
        send_beat(load_beat(1'b0, '1));
        send_beat(load_beat(1'b0, 16'h1234));
        send_beat(select_beat('1));
        send_beat(select_beat('0));
        send_beat(select_beat(16'h5555));
        send_beat(load_beat(1'b1, 16'h0042));
        send_beat(select_beat(random_fraction()));
        wait_for_results();
    endtask

    task automatic test_output_backpressure();
        send_beat(load_beat(1'b1, random_fitness()));
        hold_off_cycles = 400;
        repeat (40) begin
            if ($urandom_range(1)) begin
                send_beat(load_beat(1'b0, random_fitness()));
            end else begin
                send_beat(select_beat(random_fraction()));
            end
        end
        wait_for_results();
    endtask

    task automatic test_random_populations(input int item_budget);
        int       sent;
        int       roll;
        int       pop_size;
        int       select_total;
        t_in_item item;
        sent = 0;
        while (sent < item_budget) begin
            roll = $urandom_range(99);
            if (roll < 15) begin
                item.action          = 1'($urandom);
                item.start_new       = 1'($urandom);
                item.fitness_value   = FIT_IN_W'($urandom);
                item.random_fraction = FRAC_W'($urandom);
                send_beat(item);
                sent++;
            end else begin
                roll = $urandom_range(99);
                if (roll < 85) begin
                    pop_size = $urandom_range(1, 12);
                end else if (roll < 97) begin
                    pop_size = $urandom_range(13, 64);
                end else begin
                    pop_size = $urandom_range(65, MAX_POPULATION);
                end
                select_total = $urandom_range(1, 16);
                send_beat(load_beat(1'b1, random_fitness()));
                repeat (pop_size - 1) send_beat(load_beat(1'b0, random_fitness()));
                repeat (select_total) send_beat(select_beat(random_fraction()));
                sent += pop_size + select_total;
            end
        end
        wait_for_results();
    endtask

    initial begin : test_sequence
        held_count      = '0;
        fitness_total   = '0;
        mismatch_count  = 0;
        hold_off_cycles = 0;
        set_idling(0, 0);
        i_rst_n               <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.action          <= ACT_LOAD;
        in_ch.start_new       <= 1'b0;
        in_ch.fitness_value   <= '0;
        in_ch.random_fraction <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(25, 46);
        test_empty_select();
        test_field_extremes();
        test_all_zero_fitness();
        test_full_population();
        test_output_backpressure();
        test_random_populations(360);
        set_idling(46, 25);
        test_random_populations(360);
        set_idling(0, 0);
        test_random_populations(360);

        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0 && pending_picks.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> roulette_wheel_selector.f
+incdir+sv
sv/rws_pkg.sv
sv/rws_channels.sv
sv/rws_prefix_ram.sv
sv/roulette_wheel_selector.sv
test/tb_roulette_wheel_selector.sv
